/* rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
// Each helper samples on clk and stays quiet while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/hlg_pkg.sv */
package hlg_pkg;

    // Field and register widths
    localparam int VAL_W      = 16;
    localparam int DIFF_W     = 17;
    localparam int GRAD_W     = 17;
    localparam int MEAN_W     = 32;
    localparam int DELTA_W    = 16;
    localparam int COUNT_W    = 11;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Multiplier operands and the per-element loss
    localparam int OPA_W  = 17;
    localparam int OPB_W  = 18;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ELEM_W = 33;

    localparam int MAX_ELEMENTS_DEF = 1024;

    // Reset values of the configuration registers
    localparam logic [DELTA_W-1:0] DELTA_RESET = 16'd256;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 11'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DELTA = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_MUL,
        ST_ACC,
        ST_DIV,
        ST_DONE
    } hlg_state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic ready;
        logic load;
        logic calc;
        logic mul;
        logic acc;
        logic div_step;
        logic push;
    } hlg_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic last;
        logic div_done;
        logic out_free;
    } hlg_status_t;

endpackage

/* rtl/hlg_sample_if.sv */
interface hlg_sample_if;
    import hlg_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [VAL_W-1:0] expected;
    logic signed [VAL_W-1:0] predicted;

    modport source (output valid, output expected, output predicted, input ready);
    modport sink   (input valid, input expected, input predicted, output ready);
endinterface

/* rtl/hlg_result_if.sv */
interface hlg_result_if;
    import hlg_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [GRAD_W-1:0] gradient;
    logic [MEAN_W-1:0]        mean_loss;
    logic                     last;

    modport source (output valid, output gradient, output mean_loss, output last,
                    input ready);
    modport sink   (input valid, input gradient, input mean_loss, input last,
                    output ready);
endinterface

/* rtl/huber_loss_and_gradient.sv */
// Channel   Direction  Payload                              Handshake
// sample    in         expected, predicted (Q8.8 signed)    valid/ready
// result    out        gradient, mean_loss, last            valid/ready
// cfg       in         cfg_index, cfg_data                  cfg_we
//
// A word that does not close a vector passes through diff, operand select,
// multiply, accumulate and output load before sample ready returns.
// A word that closes a vector also runs the bit-serial mean divider
// (one quotient bit per cycle over the 43-bit loss sum).
// Reset is asynchronous, active low; it restores delta and the element count.
// A waiting result word does not block the next sample; only loading a new
// result waits for the output register to drain.
module huber_loss_and_gradient #(
    parameter int MAX_ELEMENTS = hlg_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hlg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [hlg_pkg::CFG_DATA_W-1:0] cfg_data,
    hlg_sample_if.sink                     sample,
    hlg_result_if.source                   result
);
    import hlg_pkg::*;

    hlg_cmd_t    cmd;
    hlg_status_t st;

    hlg_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample.valid),
        .st           (st),
        .cmd          (cmd)
    );

    hlg_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .expected  (sample.expected),
        .predicted (sample.predicted),
        .cmd       (cmd),
        .st        (st),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .gradient  (result.gradient),
        .mean_loss (result.mean_loss),
        .last      (result.last)
    );

    assign sample.ready = cmd.ready;

endmodule

/* rtl/hlg_ctrl.sv */
`include "assert_macros.svh"

module hlg_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                sample_valid,
    input  hlg_pkg::hlg_status_t st,
    output hlg_pkg::hlg_cmd_t    cmd
);
    import hlg_pkg::*;

    hlg_state_t state_reg;
    hlg_state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequence a word: diff, multiply, accumulate, divide (last only), output
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.ready = 1'b1;
                cmd.load  = sample_valid;
                if (sample_valid)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd.calc   = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = st.last ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                cmd.push = st.out_free;
                if (st.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    `ASSERT_NEXT(a_div_exit, state_reg == ST_DIV && st.div_done, state_reg == ST_DONE)
    `ASSERT_NOW(a_push_free, cmd.push, st.out_free && state_reg == ST_DONE)

endmodule

/* rtl/hlg_datapath.sv */
`include "assert_macros.svh"

module hlg_datapath #(
    parameter int MAX_ELEMENTS = hlg_pkg::MAX_ELEMENTS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [hlg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [hlg_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic signed [hlg_pkg::VAL_W-1:0]   expected,
    input  logic signed [hlg_pkg::VAL_W-1:0]   predicted,
    input  hlg_pkg::hlg_cmd_t                  cmd,
    output hlg_pkg::hlg_status_t               st,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [hlg_pkg::GRAD_W-1:0]  gradient,
    output logic [hlg_pkg::MEAN_W-1:0]         mean_loss,
    output logic                               last
);
    import hlg_pkg::*;

    localparam int CNT_W   = $clog2(MAX_ELEMENTS + 1);
    localparam int CW      = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
    localparam int SUM_W   = ELEM_W + $clog2(MAX_ELEMENTS);
    localparam int DCNT_W  = $clog2(SUM_W);
    localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(SUM_W - 1);

    // Configuration registers
    logic [DELTA_W-1:0] delta_reg;
    logic [COUNT_W-1:0] count_reg;

    // Item pipeline registers
    logic signed [DIFF_W-1:0] diff_reg;
    logic [OPA_W-1:0]         opa_reg;
    logic [OPB_W-1:0]         opb_reg;
    logic signed [GRAD_W-1:0] grad_reg;
    logic [PROD_W-1:0]        prod_reg;

    // Accumulator, element counter and divider
    logic [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic [SUM_W-1:0]  quot_reg;
    logic [CNT_W-1:0]  rem_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              vec_last_reg;

    // Output register
    logic                     out_valid_reg;
    logic signed [GRAD_W-1:0] gradient_reg;
    logic [MEAN_W-1:0]        mean_reg;
    logic                     last_out_reg;

    logic [CW-1:0]            count_wide;
    logic [CW-1:0]            eff_wide;
    logic [CNT_W-1:0]         eff;
    logic [DIFF_W-1:0]        mag;
    logic                     quad;
    logic [ELEM_W-1:0]        elem;
    logic [SUM_W-1:0]         sum_next;
    logic [CNT_W-1:0]         idx_next;
    logic [CNT_W:0]           rem_shift;
    logic                     rem_fit;
    logic [MEAN_W-1:0]        mean_sat;

    // Write configuration; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delta_reg <= DELTA_RESET;
            count_reg <= COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DELTA: delta_reg <= cfg_data;
                REG_COUNT: count_reg <= cfg_data[COUNT_W-1:0];
                default:   ;
            endcase
        end
    end

    // Clamp the vector length to 1..MAX_ELEMENTS
    always_comb
    begin
        count_wide = CW'(count_reg);
        if (count_reg == '0)
        begin
            eff_wide = CW'(1);
        end
        else if (count_wide > CW'(MAX_ELEMENTS))
        begin
            eff_wide = CW'(MAX_ELEMENTS);
        end
        else
        begin
            eff_wide = count_wide;
        end
    end
    assign eff = eff_wide[CNT_W-1:0];

    // Pick the region and the multiplier operands
    assign mag  = diff_reg[DIFF_W-1] ? DIFF_W'(-diff_reg) : DIFF_W'(diff_reg);
    assign quad = mag <= DIFF_W'(delta_reg);

    assign elem      = prod_reg[ELEM_W:1];
    assign sum_next  = sum_reg + SUM_W'(elem);
    assign idx_next  = idx_reg + CNT_W'(1);

    // One restoring step of the mean divider
    assign rem_shift = {rem_reg, quot_reg[SUM_W-1]};
    assign rem_fit   = rem_shift >= {1'b0, eff};

    // Saturate the quotient to 32 bits
    assign mean_sat = (|quot_reg[SUM_W-1:MEAN_W]) ? '1 : quot_reg[MEAN_W-1:0];

    // Advance the item through diff, operands and product
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            diff_reg <= DIFF_W'(expected) - DIFF_W'(predicted);
        end
        if (cmd.calc)
        begin
            if (quad)
            begin
                opa_reg  <= mag;
                opb_reg  <= OPB_W'(mag);
                grad_reg <= -diff_reg;
            end
            else
            begin
                opa_reg  <= OPA_W'(delta_reg);
                opb_reg  <= {mag, 1'b0} - OPB_W'(delta_reg);
                grad_reg <= diff_reg[DIFF_W-1] ? GRAD_W'(delta_reg)
                                               : -GRAD_W'(delta_reg);
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= PROD_W'(opa_reg) * PROD_W'(opb_reg);
        end
    end

    // Accumulate, close the vector and run the divider
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg      <= '0;
            idx_reg      <= '0;
            dcnt_reg     <= '0;
            vec_last_reg <= 1'b0;
        end
        else if (cmd.acc)
        begin
            vec_last_reg <= st.last;
            dcnt_reg     <= '0;
            if (st.last)
            begin
                sum_reg <= '0;
                idx_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_next;
                idx_reg <= idx_next;
            end
        end
        else if (cmd.div_step)
        begin
            dcnt_reg <= dcnt_reg + DCNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc)
        begin
            quot_reg <= sum_next;
            rem_reg  <= '0;
        end
        else if (cmd.div_step)
        begin
            quot_reg <= {quot_reg[SUM_W-2:0], rem_fit};
            rem_reg  <= rem_fit ? CNT_W'(rem_shift - {1'b0, eff}) : rem_shift[CNT_W-1:0];
        end
    end

    // Hold the result word until the sink takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            gradient_reg <= grad_reg;
            mean_reg     <= vec_last_reg ? mean_sat : '0;
            last_out_reg <= vec_last_reg;
        end
    end

    assign st.last     = idx_next >= eff;
    assign st.div_done = dcnt_reg == DIV_LAST;
    assign st.out_free = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign gradient  = gradient_reg;
    assign mean_loss = mean_reg;
    assign last      = last_out_reg;

    `ASSERT_NEXT(a_vec_clear, cmd.acc && st.last, sum_reg == '0 && idx_reg == '0)
    `ASSERT_NOW(a_mean_zero, out_valid_reg && !last_out_reg, mean_reg == '0)

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import hlg_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int COUNT_LIMIT   = MAX_ELEMENTS_DEF;
    // One word's pass through the block plus the mean divider, with margin
    localparam int SETTLE_CYCLES = 60;
    localparam int MAX_REPORTS   = 10;
    localparam int RUN_LIMIT_NS  = 10_000_000;

    typedef struct {
        logic signed [GRAD_W-1:0] gradient;
        logic [MEAN_W-1:0]        mean_loss;
        logic                     last;
    } loss_word_t;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    hlg_sample_if sample_bus ();
    hlg_result_if result_bus ();

    huber_loss_and_gradient i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_bus),
        .result    (result_bus)
    );

    // Shadow copy of the block's registers and accumulator
    logic [DELTA_W-1:0] cur_delta   = DELTA_RESET;
    logic [COUNT_W-1:0] cur_count   = COUNT_RESET;
    logic [63:0]        loss_total  = '0;
    int unsigned        elems_taken = 0;

    loss_word_t due_words[$];
    int         mismatches     = 0;
    bit         source_idle_on = 1'b1;
    bit         sink_idle_on   = 1'b1;
    int         sink_hold      = 0;
    int         sink_gap       = 0;

    always #(HALF_PERIOD) clk = ~clk;

    // Compute the gradient for one pair and fold its loss into the running mean
    function automatic loss_word_t huber_predict(input logic signed [VAL_W-1:0] expected,
                                                 input logic signed [VAL_W-1:0] predicted);
        logic signed [DIFF_W-1:0] diff;
        logic [63:0]              mag;
        logic [63:0]              thr;
        logic [63:0]              elem;
        logic [63:0]              avg;
        int unsigned              span;
        loss_word_t               w;
        diff = expected - predicted;
        mag  = diff < 0 ? 64'(-diff) : 64'(diff);
        thr  = 64'(cur_delta);
        if (mag <= thr)
        begin
            elem       = (mag * mag) >> 1;
            w.gradient = -diff;
        end
        else
        begin
            elem       = (thr * (2 * mag - thr)) >> 1;
            w.gradient = diff < 0 ? $signed({1'b0, cur_delta}) : -$signed({1'b0, cur_delta});
        end
        loss_total += elem;
        elems_taken++;
        // Zero count acts as one, and the count is capped at the vector limit
        span = (cur_count == 0) ? 1 : ((cur_count > COUNT_LIMIT) ? COUNT_LIMIT : cur_count);
        w.mean_loss = '0;
        w.last      = 1'b0;
        if (elems_taken >= span)
        begin
            avg         = loss_total / 64'(span);
            w.mean_loss = (avg > 64'hFFFF_FFFF) ? '1 : avg[MEAN_W-1:0];
            w.last      = 1'b1;
            loss_total  = '0;
            elems_taken = 0;
        end
        return w;
    endfunction

    // Offer one word and record its expected result once accepted
    task automatic send_word(input logic signed [VAL_W-1:0] expected,
                             input logic signed [VAL_W-1:0] predicted);
        @(negedge clk);
        if (source_idle_on && $urandom_range(0, 5) == 0)
        begin
            sample_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        sample_bus.valid     <= 1'b1;
        sample_bus.expected  <= expected;
        sample_bus.predicted <= predicted;
        do @(posedge clk); while (!sample_bus.ready);
        due_words.push_back(huber_predict(expected, predicted));
    endtask

    // Build a pair whose difference lands near the current threshold in half the cases
    task automatic send_random_word();
        logic signed [VAL_W-1:0] e;
        logic signed [VAL_W-1:0] p;
        int                      mode;
        int                      span;
        int                      offs;
        int                      pv;
        e    = VAL_W'($urandom);
        p    = VAL_W'($urandom);
        span = int'(cur_delta);
        mode = $urandom_range(0, 9);
        if (mode >= 3 && mode <= 7)
        begin
            if (mode == 7)
                offs = span + int'($urandom_range(0, 1));
            else
                offs = int'($urandom_range(0, span + 1));
            if ($urandom_range(0, 1))
                offs = -offs;
            pv = int'(e) - offs;
            if (pv > 32767)
                pv = 32767;
            else if (pv < -32768)
                pv = -32768;
            p = VAL_W'(pv);
        end
        else if (mode == 8)
        begin
            p = e;
        end
        else if (mode == 9)
        begin
            e = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            p = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end
        send_word(e, p);
    endtask

    // Drop valid and hold until every expected word is back
    task automatic drain_words(input int settle);
        @(negedge clk);
        sample_bus.valid <= 1'b0;
        while (due_words.size() != 0) @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        sample_bus.valid <= 1'b0;
        cfg_we           <= 1'b1;
        cfg_index        <= idx;
        cfg_data         <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_DELTA)
            cur_delta = data;
        else if (idx == REG_COUNT)
            cur_count = data[COUNT_W-1:0];
    endtask

    // Default threshold of 1.0 and one element per vector
    task automatic test_reset_values();
        send_word(16'sd256, 16'sd0);
        send_word(16'sd0, 16'sd257);
        send_word(16'sd100, 16'sd100);
        send_word(-16'sd512, 16'sd512);
        drain_words(4);
    endtask

    // Largest and zero differences against the widest and the narrowest threshold
    task automatic test_field_extremes();
        write_reg(REG_DELTA, 16'hFFFF);
        send_word(16'sh7FFF, 16'sh8000);
        send_word(16'sh8000, 16'sh7FFF);
        send_word(16'sh7FFF, 16'sh7FFF);
        send_word(16'sh8000, 16'sh8000);
        drain_words(4);
        write_reg(REG_DELTA, 16'h0001);
        send_word(16'sh7FFF, 16'sh8000);
        send_word(16'sh8000, 16'sh7FFF);
        drain_words(4);
    endtask

    // Zero threshold: any nonzero difference gives no loss and no gradient
    task automatic test_zero_delta();
        write_reg(REG_DELTA, 16'h0000);
        send_word(16'sd0, 16'sd0);
        send_word(16'sd5, 16'sd4);
        send_word(-16'sd300, 16'sd1000);
        drain_words(4);
    endtask

    // Zero count, a count lowered mid-vector, and masked upper data bits
    task automatic test_count_edges();
        write_reg(REG_DELTA, 16'd384);
        write_reg(REG_COUNT, 16'd0);
        send_word(16'sd1000, -16'sd1000);
        send_word(16'sd20, 16'sd90);
        drain_words(4);
        write_reg(REG_COUNT, 16'd6);
        send_word(16'sd700, 16'sd0);
        send_word(-16'sd40, 16'sd33);
        send_word(16'sh7FFF, 16'sh8000);
        drain_words(4);
        write_reg(REG_COUNT, 16'd2);
        send_word(16'sd123, -16'sd321);
        drain_words(4);
        write_reg(REG_COUNT, 16'hF803);
        send_word(16'sd1, 16'sd2);
        send_word(16'sd300, 16'sd100);
        send_word(-16'sd9000, 16'sd9000);
        drain_words(4);
    endtask

    // Count above the limit runs a full-size vector; stall the receiver at the start
    task automatic test_full_vector();
        write_reg(REG_DELTA, 16'd768);
        write_reg(REG_COUNT, 16'd2047);
        sink_hold = 400;
        repeat (COUNT_LIMIT) send_random_word();
        drain_words(4);
    endtask

    // Random threshold and count per phase; partial vectors carry across phases
    task automatic test_random_mix(input int n_items);
        int                    sent;
        int                    burst;
        logic [DELTA_W-1:0]    d;
        logic [COUNT_W-1:0]    c;
        logic [CFG_DATA_W-1:0] cdata;
        sent = 0;
        while (sent < n_items)
        begin
            drain_words(4);
            if ($urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 5))
                    0:       d = 16'h0000;
                    1:       d = 16'hFFFF;
                    2:       d = 16'h0001;
                    3:       d = DELTA_W'($urandom);
                    default: d = DELTA_W'($urandom_range(16, 2048));
                endcase
                write_reg(REG_DELTA, d);
            end
            if ($urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 5))
                    0:       c = 11'd0;
                    1:       c = 11'd1;
                    2:       c = COUNT_W'($urandom_range(1025, 2047));
                    default: c = COUNT_W'($urandom_range(2, 12));
                endcase
                cdata = CFG_DATA_W'($urandom);
                cdata[COUNT_W-1:0] = c;
                write_reg(REG_COUNT, cdata);
            end
            // Run the tail of the stream at full rate on both sides
            if (sent >= n_items * 3 / 4)
            begin
                source_idle_on = 1'b0;
                sink_idle_on   = 1'b0;
            end
            burst = $urandom_range(1, 8);
            repeat (burst) send_random_word();
            sent += burst;
        end
    endtask

    // Receiver: long hold-offs first, then random stall bursts
    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold > 0)
            begin
                result_bus.ready <= 1'b0;
                sink_hold--;
            end
            else if (sink_gap > 0)
            begin
                result_bus.ready <= 1'b0;
                sink_gap--;
            end
            else
            begin
                result_bus.ready <= 1'b1;
                if (sink_idle_on && $urandom_range(0, 6) == 0)
                    sink_gap = $urandom_range(1, 13);
            end
        end
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        loss_word_t want;
        if (rst_n && result_bus.valid && result_bus.ready)
        begin
            if (due_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected word grad=%0d mean=0x%08h last=%0b", $time,
                             result_bus.gradient, result_bus.mean_loss, result_bus.last);
            end
            else
            begin
                want = due_words.pop_front();
                if (result_bus.gradient !== want.gradient ||
                    result_bus.mean_loss !== want.mean_loss ||
                    result_bus.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: want g=%0d m=0x%08h l=%0b, got g=%0d m=0x%08h l=%0b",
                                 $time, want.gradient, want.mean_loss, want.last,
                                 result_bus.gradient, result_bus.mean_loss, result_bus.last);
                end
            end
        end
    end

    initial
    begin
        sample_bus.valid     = 1'b0;
        sample_bus.expected  = '0;
        sample_bus.predicted = '0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        test_reset_values();
        test_field_extremes();
        test_zero_delta();
        test_count_edges();
        test_full_vector();
        test_random_mix(40);
        drain_words(SETTLE_CYCLES);
        if (mismatches == 0 && due_words.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
